FILE: design/assert_macros.svh
// Assertion macros used by the allocator datapath.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Region size, derived widths, node, status, operation and state codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int TOTAL_UNITS = 1024;
   localparam int LEVELS      = $clog2(TOTAL_UNITS);
   localparam int NODE_W      = LEVELS + 1;
   localparam int RAM_DEPTH   = 1 << NODE_W;
   localparam int DEPTH_W     = $clog2(LEVELS + 1);
   localparam int ADDR_W      = 10;
   localparam int SIZE_W      = 11;

   typedef enum logic [1:0] {
      NODE_FREE  = 2'd0,
      NODE_SPLIT = 2'd1,
      NODE_ALLOC = 2'd2
   } node_state_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_SIZE  = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_CLEAR,
      DP_LOAD,
      DP_DOWN_LEFT,
      DP_DOWN_TGT,
      DP_UP,
      DP_NEXT,
      DP_ALLOC_STEP,
      DP_FREE_WR,
      DP_MERGE_UP
   } dp_op_type;

   typedef enum logic [3:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_CHECK,
      CTL_A_RD,
      CTL_A_EV,
      CTL_A_UP,
      CTL_A_MARK,
      CTL_F_RD,
      CTL_F_EV,
      CTL_M_RD,
      CTL_M_EV,
      CTL_RESP
   } ctl_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic       rd_sibling;
      logic       respond;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      node_state_type rd_state;
      logic           clr_done;
      logic           action;
      logic           bad_size;
      logic           addr_bad;
      logic           at_want;
      logic           is_leaf;
      logic           is_root;
      logic           depth_one;
      logic           bit0;
      logic           start_match;
   } dp_flags_type;

endpackage

FILE: design/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks of a region held as a binary tree.
// ----------------------------------------------------------------------------
// After reset the block clears its tree memory, one node a cycle for all 2048
// nodes, with busy high. A request word is taken when start is high and busy
// is low; its result word appears on the rsp_ ports for exactly one cycle with
// rsp_valid high, and must be taken then, as it cannot be held off. Every
// tree node visited takes a read state and an evaluate state, set by the
// registered read of the single tree memory: an allocate runs longer with more
// nodes searched, backtrack steps and levels split, and a free with more
// levels descended and buddies checked.
module buddy_block_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_action,
   input  logic [bba_pkg::SIZE_W-1:0]  req_request_size,
   input  logic [bba_pkg::ADDR_W-1:0]  req_free_address,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]  rsp_block_address,
   output logic [bba_pkg::SIZE_W-1:0]  rsp_block_size
);

   bba_pkg::dp_cmd_type   cmd;
   bba_pkg::dp_flags_type flags;
   bba_pkg::status_type   status;

   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .flags (flags),
      .cmd   (cmd)
   );

   bba_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .flags             (flags),
      .req_action        (req_action),
      .req_request_size  (req_request_size),
      .req_free_address  (req_free_address),
      .rsp_valid         (rsp_valid),
      .rsp_status        (status),
      .rsp_block_address (rsp_block_address),
      .rsp_block_size    (rsp_block_size)
   );

   assign rsp_status = status;

endmodule

FILE: design/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bba_datapath.sv
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Node tree memory, tree position registers, request capture, result words
// and the clearing counter, all driven by controller commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  bba_pkg::dp_cmd_type         cmd,
   output bba_pkg::dp_flags_type       flags,
   input  logic                        req_action,
   input  logic [bba_pkg::SIZE_W-1:0]  req_request_size,
   input  logic [bba_pkg::ADDR_W-1:0]  req_free_address,
   output logic                        rsp_valid,
   output bba_pkg::status_type         rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]  rsp_block_address,
   output logic [bba_pkg::SIZE_W-1:0]  rsp_block_size
);

   logic [bba_pkg::NODE_W-1:0]  node_ff, node_in;
   logic [bba_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic [bba_pkg::DEPTH_W-1:0] want_ff, want_in;
   logic                        action_ff, action_in;
   logic                        bad_ff, bad_in;
   logic                        abad_ff, abad_in;
   logic [bba_pkg::ADDR_W-1:0]  target_ff, target_in;
   logic [bba_pkg::NODE_W:0]    clr_ff, clr_in;
   logic [bba_pkg::ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [bba_pkg::SIZE_W-1:0]  res_size_ff, res_size_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   bba_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [bba_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [bba_pkg::SIZE_W-1:0]  rsp_size_ff, rsp_size_in;

   logic                        wr_en;
   logic [bba_pkg::NODE_W-1:0]  wr_addr;
   logic [1:0]                  wr_data;
   logic [bba_pkg::NODE_W-1:0]  rd_addr;
   logic [1:0]                  rd_data;

   logic [bba_pkg::NODE_W-1:0]  node_off;
   logic [bba_pkg::DEPTH_W-1:0] lev_rem;
   logic [bba_pkg::DEPTH_W-1:0] tgt_sh;
   logic [31:0]                 start32;
   logic [31:0]                 size32;
   logic [31:0]                 tgt32;
   logic [31:0]                 tgt_shifted;
   logic                        tbit;
   logic                        at_want;
   logic [bba_pkg::DEPTH_W-1:0] want_calc;
   logic                        found;

   bba_ram #(
      .WIDTH (2),
      .DEPTH (bba_pkg::RAM_DEPTH)
   ) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Position of the current node: its start unit and its block size.
   assign node_off    = node_ff & ~(bba_pkg::NODE_W'(1) << depth_ff);
   assign lev_rem     = bba_pkg::DEPTH_W'(bba_pkg::LEVELS) - depth_ff;
   assign start32     = 32'(node_off) << lev_rem;
   assign size32      = 32'(bba_pkg::TOTAL_UNITS) >> depth_ff;
   assign tgt32       = 32'(target_ff);
   assign tgt_sh      = bba_pkg::DEPTH_W'(bba_pkg::LEVELS - 1) - depth_ff;
   assign tgt_shifted = tgt32 >> tgt_sh;
   assign tbit        = tgt_shifted[0];
   assign at_want     = (depth_ff == want_ff);
   assign rd_addr     = cmd.rd_sibling ? (node_ff ^ bba_pkg::NODE_W'(1)) : node_ff;

   // Depth of the rounded-up request: the smallest power of two not below it.
   always_comb begin
      want_calc = '0;
      found     = 1'b0;
      for (int i = 0; i <= bba_pkg::LEVELS; i++) begin
         if (!found && ((32'(1) << i) >= 32'(req_request_size))) begin
            found     = 1'b1;
            want_calc = bba_pkg::DEPTH_W'(bba_pkg::LEVELS - i);
         end
      end
   end

   always_comb begin
      node_in       = node_ff;
      depth_in      = depth_ff;
      want_in       = want_ff;
      action_in     = action_ff;
      bad_in        = bad_ff;
      abad_in       = abad_ff;
      target_in     = target_ff;
      clr_in        = clr_ff;
      res_addr_in   = res_addr_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      wr_en         = 1'b0;
      wr_addr       = node_ff;
      wr_data       = bba_pkg::NODE_FREE;

      unique case (cmd.op)
         bba_pkg::DP_NONE: begin
         end
         bba_pkg::DP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[bba_pkg::NODE_W-1:0];
            clr_in  = clr_ff + 1'b1;
         end
         bba_pkg::DP_LOAD: begin
            node_in   = bba_pkg::NODE_W'(1);
            depth_in  = '0;
            want_in   = want_calc;
            action_in = req_action;
            target_in = req_free_address;
            bad_in    = (req_request_size == '0) ||
                        (32'(req_request_size) > 32'(bba_pkg::TOTAL_UNITS));
            abad_in   = 32'(req_free_address) >= 32'(bba_pkg::TOTAL_UNITS);
         end
         bba_pkg::DP_DOWN_LEFT: begin
            node_in  = {node_ff[bba_pkg::NODE_W-2:0], 1'b0};
            depth_in = depth_ff + 1'b1;
         end
         bba_pkg::DP_DOWN_TGT: begin
            node_in  = {node_ff[bba_pkg::NODE_W-2:0], tbit};
            depth_in = depth_ff + 1'b1;
         end
         bba_pkg::DP_UP: begin
            node_in  = node_ff >> 1;
            depth_in = depth_ff - 1'b1;
         end
         bba_pkg::DP_NEXT: begin
            node_in = node_ff + 1'b1;
         end
         bba_pkg::DP_ALLOC_STEP: begin
            wr_en = 1'b1;
            if (at_want) begin
               wr_data     = bba_pkg::NODE_ALLOC;
               res_addr_in = start32[bba_pkg::ADDR_W-1:0];
               res_size_in = size32[bba_pkg::SIZE_W-1:0];
            end else begin
               wr_data  = bba_pkg::NODE_SPLIT;
               node_in  = {node_ff[bba_pkg::NODE_W-2:0], 1'b0};
               depth_in = depth_ff + 1'b1;
            end
         end
         bba_pkg::DP_FREE_WR: begin
            wr_en       = 1'b1;
            res_addr_in = start32[bba_pkg::ADDR_W-1:0];
            res_size_in = size32[bba_pkg::SIZE_W-1:0];
         end
         bba_pkg::DP_MERGE_UP: begin
            wr_en    = 1'b1;
            wr_addr  = node_ff >> 1;
            node_in  = node_ff >> 1;
            depth_in = depth_ff - 1'b1;
         end
         default: begin
         end
      endcase

      if (cmd.respond) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.status;
         rsp_addr_in   = (cmd.status == bba_pkg::ST_OK) ? res_addr_ff : '0;
         rsp_size_in   = (cmd.status == bba_pkg::ST_OK) ? res_size_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff       <= node_in;
      depth_ff      <= depth_in;
      want_ff       <= want_in;
      action_ff     <= action_in;
      bad_ff        <= bad_in;
      abad_ff       <= abad_in;
      target_ff     <= target_in;
      res_addr_ff   <= res_addr_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign flags.rd_state    = bba_pkg::node_state_type'(rd_data);
   assign flags.clr_done    = clr_ff[bba_pkg::NODE_W];
   assign flags.action      = action_ff;
   assign flags.bad_size    = bad_ff;
   assign flags.addr_bad    = abad_ff;
   assign flags.at_want     = at_want;
   assign flags.is_leaf     = (depth_ff == bba_pkg::DEPTH_W'(bba_pkg::LEVELS));
   assign flags.is_root     = (depth_ff == '0);
   assign flags.depth_one   = (depth_ff == bba_pkg::DEPTH_W'(1));
   assign flags.bit0        = node_ff[0];
   assign flags.start_match = (start32 == tgt32);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_block_size    = rsp_size_ff;

   `ASSERT_NEXT(a_strobe_single, rsp_valid_ff, !rsp_valid_ff, "result strobe held")
   `ASSERT_SAME(a_err_zero, rsp_valid_ff && (rsp_status_ff != bba_pkg::ST_OK), (rsp_size_ff == '0) && (rsp_addr_ff == '0), "error word not zeroed")
   `ASSERT_SAME(a_ok_size, rsp_valid_ff && (rsp_status_ff == bba_pkg::ST_OK), rsp_size_ff != '0, "granted block of size zero")
   `ASSERT_SAME(a_load_cleared, cmd.op == bba_pkg::DP_LOAD, clr_ff[bba_pkg::NODE_W], "request before tree cleared")

endmodule

FILE: design/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences the clearing pass, the left-first search with backtracking,
// the split marking, the free descent and the upward merge.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bba_pkg::dp_flags_type flags,
   output bba_pkg::dp_cmd_type   cmd
);

   bba_pkg::ctl_state_type state_ff, state_in;
   bba_pkg::status_type    status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::CTL_CLEAR;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd.op         = bba_pkg::DP_NONE;
      cmd.rd_sibling = 1'b0;
      cmd.respond    = 1'b0;
      cmd.status     = status_ff;

      unique case (state_ff)
         bba_pkg::CTL_CLEAR: begin
            if (flags.clr_done) begin
               state_in = bba_pkg::CTL_IDLE;
            end else begin
               cmd.op = bba_pkg::DP_CLEAR;
            end
         end
         bba_pkg::CTL_IDLE: begin
            if (start) begin
               cmd.op   = bba_pkg::DP_LOAD;
               state_in = bba_pkg::CTL_CHECK;
            end
         end
         bba_pkg::CTL_CHECK: begin
            if (!flags.action) begin
               if (flags.bad_size) begin
                  status_in = bba_pkg::ST_BAD_SIZE;
                  state_in  = bba_pkg::CTL_RESP;
               end else begin
                  state_in = bba_pkg::CTL_A_RD;
               end
            end else if (flags.addr_bad) begin
               status_in = bba_pkg::ST_NOT_FOUND;
               state_in  = bba_pkg::CTL_RESP;
            end else begin
               state_in = bba_pkg::CTL_F_RD;
            end
         end
         bba_pkg::CTL_A_RD: begin
            state_in = bba_pkg::CTL_A_EV;
         end
         bba_pkg::CTL_A_EV: begin
            // A free node at or above the wanted size is the leftmost fit.
            if (flags.rd_state == bba_pkg::NODE_FREE) begin
               state_in = bba_pkg::CTL_A_MARK;
            end else if (flags.rd_state == bba_pkg::NODE_SPLIT && !flags.at_want) begin
               cmd.op   = bba_pkg::DP_DOWN_LEFT;
               state_in = bba_pkg::CTL_A_RD;
            end else begin
               state_in = bba_pkg::CTL_A_UP;
            end
         end
         bba_pkg::CTL_A_UP: begin
            // Climb past right children, then step to the right sibling.
            if (flags.is_root) begin
               status_in = bba_pkg::ST_FULL;
               state_in  = bba_pkg::CTL_RESP;
            end else if (flags.bit0) begin
               cmd.op = bba_pkg::DP_UP;
            end else begin
               cmd.op   = bba_pkg::DP_NEXT;
               state_in = bba_pkg::CTL_A_RD;
            end
         end
         bba_pkg::CTL_A_MARK: begin
            cmd.op = bba_pkg::DP_ALLOC_STEP;
            if (flags.at_want) begin
               status_in = bba_pkg::ST_OK;
               state_in  = bba_pkg::CTL_RESP;
            end
         end
         bba_pkg::CTL_F_RD: begin
            state_in = bba_pkg::CTL_F_EV;
         end
         bba_pkg::CTL_F_EV: begin
            if (flags.rd_state == bba_pkg::NODE_SPLIT && !flags.is_leaf) begin
               cmd.op   = bba_pkg::DP_DOWN_TGT;
               state_in = bba_pkg::CTL_F_RD;
            end else if (flags.rd_state == bba_pkg::NODE_ALLOC && flags.start_match) begin
               cmd.op    = bba_pkg::DP_FREE_WR;
               status_in = bba_pkg::ST_OK;
               state_in  = flags.is_root ? bba_pkg::CTL_RESP : bba_pkg::CTL_M_RD;
            end else begin
               status_in = bba_pkg::ST_NOT_FOUND;
               state_in  = bba_pkg::CTL_RESP;
            end
         end
         bba_pkg::CTL_M_RD: begin
            cmd.rd_sibling = 1'b1;
            state_in       = bba_pkg::CTL_M_EV;
         end
         bba_pkg::CTL_M_EV: begin
            if (flags.rd_state == bba_pkg::NODE_FREE) begin
               cmd.op   = bba_pkg::DP_MERGE_UP;
               state_in = flags.depth_one ? bba_pkg::CTL_RESP : bba_pkg::CTL_M_RD;
            end else begin
               state_in = bba_pkg::CTL_RESP;
            end
         end
         bba_pkg::CTL_RESP: begin
            cmd.respond = 1'b1;
            state_in    = bba_pkg::CTL_IDLE;
         end
         default: begin
            state_in = bba_pkg::CTL_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != bba_pkg::CTL_IDLE);

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free request words through the start/busy handshake,
// keeps its own copy of the node tree to predict each result word, and
// compares every result word field by field in order of issue.
// ----------------------------------------------------------------------------
module tb_top;

   localparam bit ACT_ALLOC = 1'b0;
   localparam bit ACT_FREE  = 1'b1;
   localparam int RANDOM_WORDS = 1900;
   localparam longint CYCLE_LIMIT = 20000000;

   typedef struct {
      bba_pkg::status_type        status;
      logic [bba_pkg::ADDR_W-1:0] addr;
      logic [bba_pkg::SIZE_W-1:0] size;
   } alloc_result_type;

   // Shadow of the allocator tree together with the queue of pending results.
   class alloc_scoreboard;
      bba_pkg::node_state_type tree[2*bba_pkg::TOTAL_UNITS];
      alloc_result_type        pending[$];
      int                      live_blocks[$];
      int                      errors;
      int                      grants, refusals, checked;

      function new();
         foreach (tree[i]) tree[i] = bba_pkg::NODE_FREE;
      endfunction

      task report(string what, int got, int want);
         $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
         errors++;
      endtask

      // Depth-first, left-first search that splits free blocks on the way down.
      function bit claim(int node, int base, int span, int want, output int addr);
         if (tree[node] == bba_pkg::NODE_ALLOC || span < want) return 0;
         if (span == want) begin
            if (tree[node] != bba_pkg::NODE_FREE) return 0;
            tree[node] = bba_pkg::NODE_ALLOC;
            addr = base;
            return 1;
         end
         if (tree[node] == bba_pkg::NODE_FREE) tree[node] = bba_pkg::NODE_SPLIT;
         if (claim(2*node, base, span/2, want, addr)) return 1;
         return claim(2*node+1, base + span/2, span/2, want, addr);
      endfunction

      function void note_request(bit action, int req_size, int target);
         alloc_result_type r;
         int node, base, span, want, addr;
         r.status = bba_pkg::ST_OK;
         r.addr = '0;
         r.size = '0;
         if (action == ACT_ALLOC) begin
            if (req_size == 0 || req_size > bba_pkg::TOTAL_UNITS) begin
               r.status = bba_pkg::ST_BAD_SIZE;
            end else begin
               want = 1;
               while (want < req_size) want = want << 1;
               if (claim(1, 0, bba_pkg::TOTAL_UNITS, want, addr)) begin
                  r.addr = bba_pkg::ADDR_W'(addr);
                  r.size = bba_pkg::SIZE_W'(want);
                  live_blocks.push_back(addr);
               end else begin
                  r.status = bba_pkg::ST_FULL;
               end
            end
         end else begin
            node = 1;
            base = 0;
            span = bba_pkg::TOTAL_UNITS;
            while (tree[node] == bba_pkg::NODE_SPLIT && span > 1) begin
               span = span / 2;
               if (target >= base + span) begin
                  base += span;
                  node = 2*node + 1;
               end else begin
                  node = 2*node;
               end
            end
            if (tree[node] == bba_pkg::NODE_ALLOC && base == target) begin
               tree[node] = bba_pkg::NODE_FREE;
               r.addr = bba_pkg::ADDR_W'(base);
               r.size = bba_pkg::SIZE_W'(span);
               while (node > 1 && tree[node ^ 1] == bba_pkg::NODE_FREE) begin
                  node = node >> 1;
                  tree[node] = bba_pkg::NODE_FREE;
               end
               foreach (live_blocks[i])
                  if (live_blocks[i] == base) begin
                     live_blocks.delete(i);
                     break;
                  end
            end else begin
               r.status = bba_pkg::ST_NOT_FOUND;
            end
         end
         pending.push_back(r);
      endfunction

      task check_result(logic [1:0] status, logic [bba_pkg::ADDR_W-1:0] addr,
                        logic [bba_pkg::SIZE_W-1:0] size);
         alloc_result_type e;
         checked++;
         if (pending.size() == 0) begin
            report("unexpected result word", status, -1);
            return;
         end
         e = pending.pop_front();
         if (status !== e.status) report("status", status, e.status);
         if (addr !== e.addr) report("block address", addr, e.addr);
         if (size !== e.size) report("block size", size, e.size);
         if (e.status == bba_pkg::ST_OK) grants++;
         else refusals++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = ACT_ALLOC;
   logic [bba_pkg::SIZE_W-1:0] req_request_size = '0;
   logic [bba_pkg::ADDR_W-1:0] req_free_address = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [bba_pkg::ADDR_W-1:0] rsp_block_address;
   logic [bba_pkg::SIZE_W-1:0] rsp_block_size;

   alloc_scoreboard sb = new();
   longint cycles = 0;
   int allocs_sent = 0, frees_sent = 0;

   buddy_block_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_request_size(req_request_size),
      .req_free_address(req_free_address), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_block_address(rsp_block_address),
      .rsp_block_size(rsp_block_size)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_block_address, rsp_block_size);
   end

   // Holds start high until the word is taken, then notes it for prediction.
   task send_word(bit action, int req_size, int target);
      @(negedge clock);
      start <= 1'b1;
      req_action <= action;
      req_request_size <= bba_pkg::SIZE_W'(req_size);
      req_free_address <= bba_pkg::ADDR_W'(target);
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_request(action, req_size, target);
      if (action == ACT_ALLOC) allocs_sent++;
      else frees_sent++;
   endtask

   // Drops start for a random number of cycles; most gaps are nil or short.
   task idle_gap();
      int n, pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) n = 0;
      else if (pick < 93) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 60);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         req_request_size <= bba_pkg::SIZE_W'($urandom);
         req_free_address <= bba_pkg::ADDR_W'($urandom);
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task send_random_word();
      int pick, sz;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         send_word(ACT_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (pick < 10) begin
         send_word(ACT_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (pick < 55 || sb.live_blocks.size() == 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) sz = $urandom_range(1, 16);
         else if (pick < 95) sz = $urandom_range(1, 1024 >> $urandom_range(0, 10));
         else sz = 1 << $urandom_range(0, 10);
         send_word(ACT_ALLOC, sz, $urandom_range(0, 1023));
      end else begin
         send_word(ACT_FREE, $urandom_range(0, 2047),
                   sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)]);
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed words: bad sizes, whole region, full region, stray frees.
      send_word(ACT_ALLOC, 0, 0);
      send_word(ACT_ALLOC, 1025, 1023);
      send_word(ACT_ALLOC, 2047, 0);
      send_word(ACT_ALLOC, 1024, 0);
      send_word(ACT_ALLOC, 1, 0);
      send_word(ACT_FREE, 0, 512);
      send_word(ACT_FREE, 0, 0);
      send_word(ACT_FREE, 0, 0);
      send_word(ACT_ALLOC, 3, 0);
      send_word(ACT_ALLOC, 1, 0);
      send_word(ACT_ALLOC, 1, 0);
      send_word(ACT_FREE, 0, 2);
      send_word(ACT_FREE, 0, 1023);
      send_word(ACT_FREE, 0, 4);
      send_word(ACT_ALLOC, 513, 0);
      send_word(ACT_ALLOC, 512, 0);
      send_word(ACT_FREE, 2047, 5);
      send_word(ACT_FREE, 0, 0);
      send_word(ACT_FREE, 0, 512);
      send_word(ACT_FREE, 0, 4);
      send_word(ACT_ALLOC, 1024, 0);
      send_word(ACT_FREE, 0, 0);

      repeat (RANDOM_WORDS) begin
         send_random_word();
         idle_gap();
      end
      @(negedge clock);
      start <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Sent %0d allocate and %0d free words; %0d result words checked.",
               allocs_sent, frees_sent, sb.checked);
      $display("Predicted %0d grants or releases, %0d error statuses.",
               sb.grants, sb.refusals);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
